@@ rtl/core/gus_pkg.sv @@
// Shared types and constants for the gray Gaussian unsharp-mask block.
// Used by gus_front, gus_back and the top level; depends on nothing else.
package gus_pkg;

    localparam int unsigned GRAY_W    = 8;
    localparam int unsigned ROW_W     = 12;
    localparam int unsigned COL_W     = 11;
    localparam int unsigned GAIN_W    = 8;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd5;
    localparam logic [CFG_W-1:0]  WIDTH_RST  = 12'd1280;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 12'd960;

    localparam int unsigned       MIN_DIM       = 3;
    localparam logic [GRAY_W-1:0] BORDER_SMOOTH = 8'd127;

    // floor(n / 3) == (n * 683) >> 11 for every n up to 766
    localparam logic [10:0]  DIV3_MUL   = 11'd683;
    localparam int unsigned  DIV3_SHIFT = 11;

    // Which results one input pixel causes
    typedef struct packed {
        logic last_row;  // (y, x) itself, on the last row
        logic row_end;   // (y-1, W-1), when x is the last column
        logic prev;      // (y-1, x-1)
    } gus_emit_t;

    typedef enum logic [1:0] {
        RES_PREV,
        RES_ROW_END,
        RES_LAST_ROW
    } gus_res_kind_t;

endpackage

@@ rtl/core/gus_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old word.
module gus_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/gus_queue.sv @@
// Small register FIFO between the front and back parts.
// Depends on nothing; width and depth come from parameters.
module gus_queue #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

@@ rtl/core/gus_front.sv @@
// Front part: pixel intake, position tracking, gray conversion, line stores,
// 3x3 window and Gaussian sum. Uses gus_pkg and one gus_ram for both lines.
module gus_front #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned EW        = 12,
    parameter int unsigned QDEPTH    = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gus_pkg::GRAY_W-1:0]          red,
    input  logic [gus_pkg::GRAY_W-1:0]          green,
    input  logic [gus_pkg::GRAY_W-1:0]          blue,
    input  logic                                frame_start,
    input  logic [EW-1:0]                       eff_w,
    input  logic [gus_pkg::ROW_W-1:0]           eff_h,
    input  logic [$clog2(QDEPTH+1)-1:0]         q_count,
    output logic                                push,
    output gus_pkg::gus_emit_t                  push_emit,
    output logic [$clog2(MAX_WIDTH)-1:0]        push_x,
    output logic [gus_pkg::ROW_W-1:0]           push_y,
    output logic [gus_pkg::GRAY_W-1:0]          push_center,
    output logic [gus_pkg::GRAY_W-1:0]          push_smooth,
    output logic [gus_pkg::GRAY_W-1:0]          push_mid,
    output logic [gus_pkg::GRAY_W-1:0]          push_gray
);

    localparam int unsigned XW  = $clog2(MAX_WIDTH);
    localparam int unsigned GW  = gus_pkg::GRAY_W;
    localparam int unsigned RW  = gus_pkg::ROW_W;
    localparam int unsigned QCW = $clog2(QDEPTH + 1);

    logic accept;

    // position counters
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] c0, x0;
    logic [RW-1:0] r0, y0;
    logic [RW:0]   r1;
    logic          stale;
    logic [EW-1:0] x_inc;
    logic [RW:0]   y_inc;

    logic [9:0]    rgb_sum;
    logic [20:0]   div_prod;
    logic [GW-1:0] gray0;

    gus_pkg::gus_emit_t emit0;
    logic          inner0;

    // stage 1
    logic               s1_valid_reg;
    logic [XW-1:0]      s1_x_reg;
    logic [RW-1:0]      s1_y_reg;
    logic [GW-1:0]      s1_gray_reg;
    gus_pkg::gus_emit_t s1_emit_reg;
    logic               s1_inner_reg;
    logic               s1_fwd_reg;
    logic [2*GW-1:0]    s1_fwd_data_reg;

    logic [2*GW-1:0] ram_rdata;
    logic [2*GW-1:0] line_word;
    logic [GW-1:0]   top, mid;
    logic [GW-1:0]   win_reg [6];
    logic [11:0]     gsum;
    logic [11:0]     gsum_rnd;

    assign in_ready = ({1'b0, q_count} + (QCW + 1)'(s1_valid_reg)) < (QCW + 1)'(QDEPTH);
    assign accept   = in_valid && in_ready;

    // Position of this pixel, with the frame-start and stale-position rules
    always_comb
    begin
        c0    = frame_start ? '0 : col_reg;
        r0    = frame_start ? '0 : row_reg;
        stale = (EW'(c0) >= eff_w);
        x0    = stale ? '0 : c0;
        r1    = stale ? ({1'b0, r0} + 1'b1) : {1'b0, r0};
        y0    = (r1 >= {1'b0, eff_h}) ? '0 : r1[RW-1:0];

        x_inc = EW'(x0) + 1'b1;
        y_inc = {1'b0, y0} + 1'b1;
        if (x_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (y_inc >= {1'b0, eff_h}) ? '0 : y_inc[RW-1:0];
        end
        else
        begin
            col_next = XW'(x_inc);
            row_next = y0;
        end

        emit0.prev     = (y0 != '0) && (x0 != '0);
        emit0.row_end  = (y0 != '0) && (EW'(x0) == eff_w - 1'b1);
        emit0.last_row = (y0 == eff_h - 1'b1);
        inner0         = (y0 >= RW'(2)) && (x0 >= XW'(2));

        rgb_sum  = 10'(red) + 10'(green) + 10'(blue) + 10'd1;
        div_prod = 21'(rgb_sum) * 21'(gus_pkg::DIV3_MUL);
        gray0    = div_prod[gus_pkg::DIV3_SHIFT +: GW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg        <= x0;
            s1_y_reg        <= y0;
            s1_gray_reg     <= gray0;
            s1_emit_reg     <= emit0;
            s1_inner_reg    <= inner0;
            // the line word at this column is being rewritten right now
            s1_fwd_reg      <= s1_valid_reg && (s1_x_reg == x0);
            s1_fwd_data_reg <= {s1_gray_reg, mid};
        end
    end

    // One RAM holds both line stores: upper byte is the prior row, lower the older row
    gus_ram #(
        .WIDTH (2 * GW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata ({s1_gray_reg, mid}),
        .re    (accept),
        .raddr (x0),
        .rdata (ram_rdata)
    );

    assign line_word = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign mid       = line_word[2*GW-1:GW];
    assign top       = line_word[GW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_gray_reg;
        end
    end

    always_comb
    begin
        gsum = 12'(win_reg[0]) + {3'b0, win_reg[1], 1'b0} + 12'(top)
             + {3'b0, win_reg[2], 1'b0} + {2'b0, win_reg[3], 2'b0} + {3'b0, mid, 1'b0}
             + 12'(win_reg[4]) + {3'b0, win_reg[5], 1'b0} + 12'(s1_gray_reg);
        gsum_rnd = gsum + 12'd8;
    end

    assign push        = s1_valid_reg && (s1_emit_reg != '0);
    assign push_emit   = s1_emit_reg;
    assign push_x      = s1_x_reg;
    assign push_y      = s1_y_reg;
    assign push_center = win_reg[3];
    assign push_smooth = s1_inner_reg ? gsum_rnd[11:4] : gus_pkg::BORDER_SMOOTH;
    assign push_mid    = mid;
    assign push_gray   = s1_gray_reg;

endmodule

@@ rtl/core/gus_back.sv @@
// Back part: walks the results of one queued pixel, sharpens and clamps each,
// and holds it in the output register. Uses gus_pkg.
module gus_back #(
    parameter int unsigned XW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  gus_pkg::gus_emit_t            head_emit,
    input  logic [XW-1:0]                 head_x,
    input  logic [gus_pkg::ROW_W-1:0]     head_y,
    input  logic [gus_pkg::GRAY_W-1:0]    head_center,
    input  logic [gus_pkg::GRAY_W-1:0]    head_smooth,
    input  logic [gus_pkg::GRAY_W-1:0]    head_mid,
    input  logic [gus_pkg::GRAY_W-1:0]    head_gray,
    input  logic [gus_pkg::GAIN_W-1:0]    gain,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gus_pkg::GRAY_W-1:0]    out_sharp,
    output logic [gus_pkg::ROW_W-1:0]     out_row,
    output logic [gus_pkg::COL_W-1:0]     out_col,
    output logic                          out_last
);

    localparam int unsigned GW = gus_pkg::GRAY_W;
    localparam int unsigned RW = gus_pkg::ROW_W;

    logic [2:0]             done_reg, done_next;
    logic [2:0]             pend, sel_mask, rest;
    gus_pkg::gus_res_kind_t kind;
    logic [GW-1:0]          g, s;
    logic [RW-1:0]          row;
    logic [XW-1:0]          col;
    logic                   last, load;

    logic signed [8:0]      diff;
    logic signed [16:0]     prod;
    logic signed [17:0]     val;
    logic [GW-1:0]          sharp;

    logic                   out_valid_reg, out_valid_next;
    logic [GW-1:0]          out_sharp_reg;
    logic [RW-1:0]          out_row_reg;
    logic [gus_pkg::COL_W-1:0] out_col_reg;
    logic                   out_last_reg;

    always_comb
    begin
        pend = {head_emit.last_row, head_emit.row_end, head_emit.prev} & ~done_reg;
        if (pend[0])
        begin
            kind = gus_pkg::RES_PREV;
        end
        else if (pend[1])
        begin
            kind = gus_pkg::RES_ROW_END;
        end
        else
        begin
            kind = gus_pkg::RES_LAST_ROW;
        end

        unique case (kind)
            gus_pkg::RES_PREV:
            begin
                g        = head_center;
                s        = head_smooth;
                row      = head_y - 1'b1;
                col      = head_x - 1'b1;
                sel_mask = 3'b001;
            end
            gus_pkg::RES_ROW_END:
            begin
                g        = head_mid;
                s        = gus_pkg::BORDER_SMOOTH;
                row      = head_y - 1'b1;
                col      = head_x;
                sel_mask = 3'b010;
            end
            default:
            begin
                g        = head_gray;
                s        = gus_pkg::BORDER_SMOOTH;
                row      = head_y;
                col      = head_x;
                sel_mask = 3'b100;
            end
        endcase

        rest = pend & ~sel_mask;
        last = (rest == '0);
        load = head_valid && (!out_valid_reg || out_ready);
        pop  = load && last;

        // clamp at full precision
        diff = $signed({1'b0, g}) - $signed({1'b0, s});
        prod = $signed(gain) * diff;
        val  = $signed({10'b0, g}) + $signed({prod[16], prod});
        if (val < 0)
        begin
            sharp = '0;
        end
        else if (val > 18'sd255)
        begin
            sharp = 8'd255;
        end
        else
        begin
            sharp = val[GW-1:0];
        end

        if (load)
        begin
            done_next      = last ? '0 : (done_reg | sel_mask);
            out_valid_next = 1'b1;
        end
        else
        begin
            done_next      = done_reg;
            out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_sharp_reg <= sharp;
            out_row_reg   <= row;
            out_col_reg   <= gus_pkg::COL_W'(col);
            out_last_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sharp = out_sharp_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/core/gray_gauss_unsharp_mask.sv @@
// Top level of the gray Gaussian unsharp-mask block: config registers, front,
// queue and back. Uses gus_pkg, gus_front, gus_queue, gus_back (gus_ram inside front).
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    tdata {blue, green, red}, tuser frame_start
//   m_*       out  m_tvalid / m_tready    tdata {col, row, sharpened}, tlast last_of_run
//   cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel beat is taken every cycle while the four-entry queue, counting the
// beat held in the front stage, has room. The front spends one register stage
// per pixel (line RAM read, window sum formed from the read data), then pushes
// it into the queue; drop pixels that cause no result there. The back loads the
// first result into the output register once the pixel is at the queue head and
// the output register is free. The back sends one result beat per cycle while
// m_tready is high; each extra result of a row end or a last-row pixel holds the
// pixel at the queue head. The queue absorbs that, and the input stalls only once
// the queue fills, as along the last row (two or three per pixel).
// Reset clears counters, window, queue and output valid; the line RAM is not
// cleared, each entry is written in row 0 before a later row uses it.
// cfg_ready is always high; write registers only while the block is idle.
module gray_gauss_unsharp_mask #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // frame_start
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // sharpened, row_index, col_index, 0
    output logic                             m_tlast,   // last_of_run
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gus_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gus_pkg::CFG_W-1:0]        cfg_data
);

    localparam int unsigned XW     = $clog2(MAX_WIDTH);
    localparam int unsigned EW     = ($clog2(MAX_WIDTH + 1) > gus_pkg::CFG_W) ?
                                     $clog2(MAX_WIDTH + 1) : gus_pkg::CFG_W;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned GW     = gus_pkg::GRAY_W;
    localparam int unsigned RW     = gus_pkg::ROW_W;
    localparam int unsigned EMW    = $bits(gus_pkg::gus_emit_t);
    localparam int unsigned QW     = EMW + XW + RW + 4 * GW;

    // configuration registers
    logic [gus_pkg::GAIN_W-1:0] gain_reg;
    logic [gus_pkg::CFG_W-1:0]  width_reg;
    logic [gus_pkg::CFG_W-1:0]  height_reg;
    logic [EW-1:0]              width_ext, eff_w;
    logic [RW-1:0]              eff_h;

    // front to queue
    logic                       push;
    gus_pkg::gus_emit_t         push_emit;
    logic [XW-1:0]              push_x;
    logic [RW-1:0]              push_y;
    logic [GW-1:0]              push_center, push_smooth, push_mid, push_gray;

    // queue to back
    logic [QW-1:0]              q_din, q_dout;
    logic                       q_not_empty, pop;
    logic [$clog2(QDEPTH+1)-1:0] q_count;
    gus_pkg::gus_emit_t         head_emit;
    logic [XW-1:0]              head_x;
    logic [RW-1:0]              head_y;
    logic [GW-1:0]              head_center, head_smooth, head_mid, head_gray;

    logic [GW-1:0]              out_sharp;
    logic [RW-1:0]              out_row;
    logic [gus_pkg::COL_W-1:0]  out_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= gus_pkg::GAIN_RST;
            width_reg  <= gus_pkg::WIDTH_RST;
            height_reg <= gus_pkg::HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gus_pkg::CFG_GAIN:   gain_reg   <= cfg_data[gus_pkg::GAIN_W-1:0];
                gus_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                gus_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default:             ;  // drop writes past the register list
            endcase
        end
    end

    // Limit width to [3, MAX_WIDTH] and height to at least 3
    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(gus_pkg::MIN_DIM))
        begin
            eff_w = EW'(gus_pkg::MIN_DIM);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_ext;
        end
        eff_h = (height_reg < RW'(gus_pkg::MIN_DIM)) ? RW'(gus_pkg::MIN_DIM) : height_reg;
    end

    gus_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .EW        (EW),
        .QDEPTH    (QDEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .frame_start (s_tuser),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .q_count     (q_count),
        .push        (push),
        .push_emit   (push_emit),
        .push_x      (push_x),
        .push_y      (push_y),
        .push_center (push_center),
        .push_smooth (push_smooth),
        .push_mid    (push_mid),
        .push_gray   (push_gray)
    );

    assign q_din = {push_emit, push_x, push_y, push_center, push_smooth, push_mid, push_gray};

    gus_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (q_din),
        .pop       (pop),
        .dout      (q_dout),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign {head_emit, head_x, head_y, head_center, head_smooth, head_mid, head_gray} = q_dout;

    gus_back #(
        .XW (XW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_not_empty),
        .head_emit   (head_emit),
        .head_x      (head_x),
        .head_y      (head_y),
        .head_center (head_center),
        .head_smooth (head_smooth),
        .head_mid    (head_mid),
        .head_gray   (head_gray),
        .gain        (gain_reg),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sharp   (out_sharp),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_last    (m_tlast)
    );

    // pack the result beat, sharpened value in the low byte
    assign m_tdata = {1'b0, out_col, out_row, out_sharp};

endmodule
